FILE: hw/rtl/pls_pkg.sv
// types, constants and helper functions shared by the playlist parser
`timescale 1ns / 1ps

package pls_pkg;

    localparam int unsigned HDR_LEN = 10;
    localparam int unsigned KEY_LEN = 4;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = 2;
    localparam int unsigned FIFO_CNT_W = 3;

    localparam logic [7:0] CH_EOT = 8'h00;
    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_EQ = 8'h3d;

    localparam logic [15:0] COUNT_MAX = 16'hffff;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_LINE    = 3'd1,
        PH_KEY     = 3'd2,
        PH_VALUE   = 3'd3,
        PH_SKIP    = 3'd4,
        PH_ERRWAIT = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        K_BYTE = 2'd0,
        K_EOV  = 2'd1,
        K_DONE = 2'd2,
        K_ERR  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  value_byte;
        logic [15:0] entry_count;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5a)
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic [7:0] hdr_char(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0: r = 8'h5b;
            4'd1: r = 8'h70;
            4'd2: r = 8'h6c;
            4'd3: r = 8'h61;
            4'd4: r = 8'h79;
            4'd5: r = 8'h6c;
            4'd6: r = 8'h69;
            4'd7: r = 8'h73;
            4'd8: r = 8'h74;
            4'd9: r = 8'h5d;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0: r = 8'h66;
            4'd1: r = 8'h69;
            4'd2: r = 8'h6c;
            4'd3: r = 8'h65;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/pls_playlist_file_entry_parser_core.sv
// Playlist text parser: takes one text byte per transaction and streams out the
// values of File entries, end-of-value marks, a done result with the entry count
// and format errors. A byte is accepted every cycle while the result queue has
// room; it is held in the input register, parsed in a single pass against the
// state registers, and its results are written into a four-entry result queue,
// from which they are offered. The queue drains one result per cycle while
// out_ready is high, and a byte that ends the text inside a value gives two
// results (end of value plus done); input ready drops while the queue holds more
// than two results and the input register is still full.
`timescale 1ns / 1ps

module pls_playlist_file_entry_parser_core
    import pls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  value_byte,
    output logic [15:0] entry_count,
    output logic        last_of_run
);

    logic       full_reg;
    logic [7:0] byte_reg;
    logic       room2;
    logic       step;
    push_t      push;
    result_t    out_res;

    assign step     = full_reg && room2;
    assign in_ready = !full_reg || step;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else if (in_ready)
            full_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= text_byte;
    end

    pls_parse_step u_step
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .text_byte (byte_reg),
        .push      (push)
    );

    pls_result_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room2     (room2),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign kind        = out_res.kind;
    assign value_byte  = out_res.value_byte;
    assign entry_count = out_res.entry_count;
    assign last_of_run = out_res.last_of_run;

endmodule

FILE: hw/rtl/pls_parse_step.sv
// parser state registers and per-byte next state and result logic
`timescale 1ns / 1ps

module pls_parse_step
    import pls_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] text_byte,
    output push_t      push
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  match_index_reg, match_index_next;
    logic        match_failed_reg, match_failed_next;
    logic [15:0] file_count_reg, file_count_next;

    logic       eot, eol, is_eq;
    logic [7:0] fc;
    logic       err, done, emit_eov, emit_byte, go_reset;

    assign eot   = (text_byte == CH_EOT);
    assign eol   = (text_byte == CH_LF) || (text_byte == CH_CR);
    assign is_eq = (text_byte == CH_EQ);
    assign fc    = fold(text_byte);

    // next state
    always_comb
    begin
        phase_next        = phase_reg;
        match_index_next  = match_index_reg;
        match_failed_next = match_failed_reg;
        file_count_next   = file_count_reg;
        err       = 1'b0;
        done      = 1'b0;
        emit_eov  = 1'b0;
        emit_byte = 1'b0;
        go_reset  = 1'b0;
        case (phase_reg)
            PH_HEADER:
            begin
                if (eot)
                begin
                    if (match_index_reg >= 4'(HDR_LEN))
                        done = 1'b1;
                    else
                        err = 1'b1;
                end
                else if (eol)
                begin
                    if (match_index_reg >= 4'(HDR_LEN))
                        phase_next = PH_LINE;
                    else if (match_index_reg != 4'd0)
                        err = 1'b1;
                end
                else if (match_index_reg < 4'(HDR_LEN))
                begin
                    if (fc == hdr_char(match_index_reg))
                        match_index_next = match_index_reg + 4'd1;
                    else
                        err = 1'b1;
                end
            end
            PH_LINE:
            begin
                if (eot)
                    done = 1'b1;
                else if (eol)
                    phase_next = PH_LINE;
                else if (is_eq)
                    phase_next = PH_SKIP;
                else
                begin
                    phase_next        = PH_KEY;
                    match_failed_next = (fc != key_char(4'd0));
                    match_index_next  = (fc != key_char(4'd0)) ? 4'd0 : 4'd1;
                end
            end
            PH_KEY:
            begin
                if (eot || eol)
                    err = 1'b1;
                else if (is_eq)
                begin
                    if (!match_failed_reg && match_index_reg >= 4'(KEY_LEN))
                        phase_next = PH_VALUE;
                    else
                        phase_next = PH_SKIP;
                end
                else if (!match_failed_reg && match_index_reg < 4'(KEY_LEN))
                begin
                    if (fc == key_char(match_index_reg))
                        match_index_next = match_index_reg + 4'd1;
                    else
                        match_failed_next = 1'b1;
                end
            end
            PH_VALUE:
            begin
                if (eot || eol)
                begin
                    emit_eov = 1'b1;
                    if (file_count_reg != COUNT_MAX)
                        file_count_next = file_count_reg + 16'd1;
                    if (eot)
                        done = 1'b1;
                    else
                        phase_next = PH_LINE;
                end
                else
                    emit_byte = 1'b1;
            end
            PH_SKIP:
            begin
                if (eot)
                    done = 1'b1;
                else if (eol)
                    phase_next = PH_LINE;
            end
            default:
            begin
                if (eot)
                    go_reset = 1'b1;
            end
        endcase
        if (err)
        begin
            if (eot)
                go_reset = 1'b1;
            else
                phase_next = PH_ERRWAIT;
        end
        else if (done)
            go_reset = 1'b1;
    end

    // results of this byte, count taken before any return to reset
    always_comb
    begin
        push = '0;
        if (step)
        begin
            if (emit_eov || emit_byte)
            begin
                push.v0             = 1'b1;
                push.r0.kind        = emit_eov ? K_EOV : K_BYTE;
                push.r0.value_byte  = emit_eov ? 8'h00 : text_byte;
                push.r0.entry_count = file_count_next;
                push.r0.last_of_run = !(emit_eov && done);
                if (emit_eov && done)
                begin
                    push.v1             = 1'b1;
                    push.r1.kind        = K_DONE;
                    push.r1.value_byte  = 8'h00;
                    push.r1.entry_count = file_count_next;
                    push.r1.last_of_run = 1'b1;
                end
            end
            else if (err || done)
            begin
                push.v0             = 1'b1;
                push.r0.kind        = err ? K_ERR : K_DONE;
                push.r0.value_byte  = 8'h00;
                push.r0.entry_count = file_count_next;
                push.r0.last_of_run = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            match_index_reg  <= 4'd0;
            match_failed_reg <= 1'b0;
            file_count_reg   <= 16'd0;
        end
        else if (step)
        begin
            if (go_reset)
            begin
                phase_reg        <= PH_HEADER;
                match_index_reg  <= 4'd0;
                match_failed_reg <= 1'b0;
                file_count_reg   <= 16'd0;
            end
            else
            begin
                phase_reg        <= phase_next;
                match_index_reg  <= match_index_next;
                match_failed_reg <= match_failed_next;
                file_count_reg   <= file_count_next;
            end
        end
    end

endmodule

FILE: hw/rtl/pls_result_fifo.sv
// result queue taking up to two results per cycle and giving one while out_ready is high
`timescale 1ns / 1ps

module pls_result_fifo
    import pls_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room2,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    result_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg, count_next;
    logic                    pop;
    logic [FIFO_CNT_W-1:0]   n_push;
    logic [FIFO_PTR_W-1:0]   wr_ptr_p1;

    assign out_valid = (count_reg != '0);
    assign out_res   = mem_reg[rd_ptr_reg];
    assign room2     = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign pop       = out_valid && out_ready;
    assign wr_ptr_p1 = wr_ptr_reg + FIFO_PTR_W'(1);

    always_comb
    begin
        n_push      = FIFO_CNT_W'(push.v0) + FIFO_CNT_W'(push.v1);
        wr_ptr_next = wr_ptr_reg + n_push[FIFO_PTR_W-1:0];
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + n_push - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.v0)
            mem_reg[wr_ptr_reg] <= push.r0;
        if (push.v1)
            mem_reg[wr_ptr_p1] <= push.r1;
    end

endmodule

FILE: dv/tb_pls_playlist_file_entry_parser_core.sv
// self-checking testbench for the playlist file entry parser core
`timescale 1ns / 1ps

module tb_pls_playlist_file_entry_parser_core;
    import pls_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_BYTES = 600;
    localparam int CALM_ENTRIES = 20;
    localparam int DIR_ROWS = 16;

    localparam logic [8*HDR_LEN-1:0] HDR_PAT = "[playlist]";
    localparam logic [8*KEY_LEN-1:0] KEY_PAT = "file";

    typedef struct {
        string       txt;
        bit          typed;
        kind_t       k;
        logic [15:0] cnt;
    } dir_row_t;

    // each row is one whole text; its end-of-text byte is appended
    dir_row_t dir_tab [DIR_ROWS] = '{
        '{"", 1'b1, K_ERR, 16'd0},
        '{"\n\015\n", 1'b1, K_ERR, 16'd0},
        '{"[playlisX", 1'b1, K_ERR, 16'd0},
        '{"{playlist]\nfile=a\n", 1'b1, K_ERR, 16'd0},
        '{"[PlayList", 1'b1, K_ERR, 16'd0},
        '{"[play\n", 1'b1, K_ERR, 16'd0},
        '{"\015\n[PLAYLIST]", 1'b1, K_DONE, 16'd0},
        '{"[playlist]\nnoeq\n", 1'b1, K_ERR, 16'd0},
        '{"[playlist]\n=x\n\015", 1'b1, K_DONE, 16'd0},
        '{"[playlist]\nfile\n", 1'b1, K_ERR, 16'd0},
        '{"[playlist]\nf", 1'b1, K_ERR, 16'd0},
        '{"[playlist]junk\nFILE2=\n", 1'b0, K_BYTE, 16'd0},
        '{"[playlist]\nfile9=\377\001zZ=", 1'b0, K_BYTE, 16'd0},
        '{"[playlist]\n\306ile=x\nFil=y\nFile@=\200\015\nTitle1=q\n\nNumberOfEntries=1\015\n",
          1'b0, K_BYTE, 16'd0},
        '{"[playlist]\nfile1=a\015\nfile2", 1'b0, K_BYTE, 16'd0},
        '{"[playlist]\nfile1=x\nbad\n[playlist]\nfile2=y\n", 1'b0, K_BYTE, 16'd0}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  text_byte;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [7:0]  value_byte;
    logic [15:0] entry_count;
    logic        last_of_run;

    logic [7:0]  text_q [$];
    result_t     result_due_q [$];

    phase_t      prs_phase;
    logic [3:0]  prs_match;
    logic        prs_miss;
    logic [15:0] prs_files;

    logic        in_took = 1'b0;
    int          feed_idx = 0;
    int          in_count = 0;
    int          seen_results = 0;
    int          mismatches = 0;
    int          stall_cycles = 0;
    int          calm_lo = 0;
    int          calm_hi = 0;
    int          squeeze_at = 0;
    int          hold_left = 0;
    bit          squeezed = 1'b0;

    pls_playlist_file_entry_parser_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .value_byte  (value_byte),
        .entry_count (entry_count),
        .last_of_run (last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
        begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] c);
        if (((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) && $urandom_range(1) == 1)
        begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    function automatic logic [7:0] value_char();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(1, 255));
        end
        while (c == CH_LF || c == CH_CR);
        return c;
    endfunction

    function automatic result_t outcome(input kind_t k, input logic [7:0] b);
        return '{kind: k, value_byte: b, entry_count: prs_files, last_of_run: 1'b0};
    endfunction

    function automatic bit steady();
        return in_count >= calm_lo && in_count < calm_hi;
    endfunction

    task automatic restart_parse();
        prs_phase = PH_HEADER;
        prs_match = 4'd0;
        prs_miss  = 1'b0;
        prs_files = 16'd0;
    endtask

    task automatic parse_byte(input logic [7:0] c);
        result_t r [2];
        int      n;
        logic    eot;
        logic    eol;
        logic    err;
        logic    fin;
        n   = 0;
        eot = (c == CH_EOT);
        eol = (c == CH_LF || c == CH_CR);
        err = 1'b0;
        fin = 1'b0;
        case (prs_phase)
            PH_HEADER:
            begin
                if (eot)
                begin
                    if (prs_match >= 4'(HDR_LEN))
                        fin = 1'b1;
                    else
                        err = 1'b1;
                end
                else if (eol)
                begin
                    if (prs_match >= 4'(HDR_LEN))
                        prs_phase = PH_LINE;
                    else if (prs_match != 4'd0)
                        err = 1'b1;
                end
                else if (prs_match < 4'(HDR_LEN))
                begin
                    if (to_lower(c) == HDR_PAT[8*(HDR_LEN-1-prs_match) +: 8])
                        prs_match++;
                    else
                        err = 1'b1;
                end
            end
            PH_LINE:
            begin
                if (eot)
                begin
                    fin = 1'b1;
                end
                else if (c == CH_EQ)
                begin
                    prs_phase = PH_SKIP;
                end
                else if (!eol)
                begin
                    prs_phase = PH_KEY;
                    prs_miss  = (to_lower(c) != KEY_PAT[8*(KEY_LEN-1) +: 8]);
                    prs_match = prs_miss ? 4'd0 : 4'd1;
                end
            end
            PH_KEY:
            begin
                if (eot || eol)
                begin
                    err = 1'b1;
                end
                else if (c == CH_EQ)
                begin
                    prs_phase = (!prs_miss && prs_match >= 4'(KEY_LEN)) ? PH_VALUE : PH_SKIP;
                end
                else if (!prs_miss && prs_match < 4'(KEY_LEN))
                begin
                    if (to_lower(c) == KEY_PAT[8*(KEY_LEN-1-prs_match) +: 8])
                        prs_match++;
                    else
                        prs_miss = 1'b1;
                end
            end
            PH_VALUE:
            begin
                if (eot || eol)
                begin
                    if (prs_files != COUNT_MAX)
                        prs_files++;
                    r[n] = outcome(K_EOV, 8'h00);
                    n++;
                    if (eot)
                        fin = 1'b1;
                    else
                        prs_phase = PH_LINE;
                end
                else
                begin
                    r[n] = outcome(K_BYTE, c);
                    n++;
                end
            end
            PH_SKIP:
            begin
                if (eot)
                    fin = 1'b1;
                else if (eol)
                    prs_phase = PH_LINE;
            end
            default:
            begin
                if (eot)
                    restart_parse();
            end
        endcase
        if (err)
        begin
            r[n] = outcome(K_ERR, 8'h00);
            n++;
            if (eot)
                restart_parse();
            else
                prs_phase = PH_ERRWAIT;
        end
        else if (fin)
        begin
            r[n] = outcome(K_DONE, 8'h00);
            n++;
            restart_parse();
        end
        if (n > 0)
        begin
            r[n-1].last_of_run = 1'b1;
        end
        for (int i = 0; i < n; i++)
        begin
            result_due_q.push_back(r[i]);
        end
    endtask

    task automatic put_byte(input logic [7:0] c);
        text_q.push_back(c);
        parse_byte(c);
    endtask

    task automatic put_word(input string s, input bit mixed);
        for (int i = 0; i < s.len(); i++)
        begin
            put_byte(mixed ? flip_case(s[i]) : s[i]);
        end
    endtask

    task automatic put_eol();
        case ($urandom_range(2))
            0: put_byte(CH_LF);
            1: put_byte(CH_CR);
            default:
            begin
                put_byte(CH_CR);
                put_byte(CH_LF);
            end
        endcase
    endtask

    task automatic put_value();
        repeat ($urandom_range(0, 8))
        begin
            put_byte(value_char());
        end
    endtask

    // input side: one transaction offered at a time, payload held until taken
    always @(negedge clk)
    begin : feed
        logic       nv;
        logic [7:0] nb;
        nv = in_valid && !in_took;
        nb = text_byte;
        if (!nv && rst_n && feed_idx < text_q.size())
        begin
            if (steady() || $urandom_range(99) >= 25)
            begin
                nv = 1'b1;
                nb = text_q[feed_idx];
                feed_idx++;
            end
        end
        in_valid  <= nv;
        text_byte <= nb;
    end

    // output side, with one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (!squeezed && in_count >= squeeze_at)
        begin
            squeezed  = 1'b1;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= steady() || $urandom_range(99) >= 25;
        end
    end

    // result transaction check
    always @(posedge clk)
    begin : monitor
        result_t want;
        in_took <= in_valid && in_ready;
        if (in_valid && in_ready)
        begin
            in_count <= in_count + 1;
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (rst_n && out_valid && out_ready)
        begin
            if (result_due_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result %0d: kind %0d byte %02h count %0d last %0b",
                             seen_results, kind, value_byte, entry_count, last_of_run);
                end
            end
            else
            begin
                want = result_due_q.pop_front();
                if (kind !== want.kind || value_byte !== want.value_byte ||
                    entry_count !== want.entry_count || last_of_run !== want.last_of_run)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result %0d: expected kind %0d byte %02h count %0d last %0b",
                                 seen_results, want.kind, want.value_byte, want.entry_count,
                                 want.last_of_run);
                        $display("result %0d: got      kind %0d byte %02h count %0d last %0b",
                                 seen_results, kind, value_byte, entry_count, last_of_run);
                    end
                end
            end
            seen_results++;
        end
    end

    initial
    begin : watchdog
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
        end
        $display("pls_playlist_file_entry_parser_core regression: fail");
        $finish;
    end

    initial
    begin : main
        int mark;
        int seg_start;
        int mode;
        int sel;
        bit broken;
        string hdr_word;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        text_byte = 8'h00;
        out_ready = 1'b0;
        hdr_word  = "[playlist]";
        restart_parse();

        // directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            mark = result_due_q.size();
            put_word(dir_tab[i].txt, 1'b0);
            put_byte(CH_EOT);
            if (dir_tab[i].typed)
            begin
                while (result_due_q.size() > mark)
                begin
                    void'(result_due_q.pop_back());
                end
                result_due_q.push_back('{kind: dir_tab[i].k, value_byte: 8'h00,
                                         entry_count: dir_tab[i].cnt, last_of_run: 1'b1});
            end
        end

        // random texts, mostly well formed
        seg_start  = text_q.size();
        squeeze_at = seg_start + 300;
        while (text_q.size() - seg_start < RANDOM_BYTES)
        begin
            mode = $urandom_range(99);
            broken = (mode >= 75);
            if (mode >= 90)
            begin
                repeat ($urandom_range(1, 24))
                begin
                    put_byte(8'($urandom_range(1, 255)));
                end
            end
            else
            begin
                if ($urandom_range(7) == 0)
                    put_eol();
                if (broken && $urandom_range(2) == 0)
                begin
                    put_word(hdr_word.substr(0, int'($urandom_range(0, 9)) - 1), 1'b1);
                    put_byte(value_char());
                end
                else
                begin
                    put_word("[playlist]", 1'b1);
                    if ($urandom_range(5) == 0)
                        put_word("x1", 1'b0);
                end
                repeat ($urandom_range(0, 6))
                begin
                    put_eol();
                    if ($urandom_range(5) == 0)
                        put_eol();
                    sel = $urandom_range(99);
                    if (sel < 50 || (sel >= 85 && !broken))
                    begin
                        put_word("file", 1'b1);
                        repeat ($urandom_range(0, 2))
                        begin
                            put_byte(8'($urandom_range("0", "9")));
                        end
                        put_byte(CH_EQ);
                        put_value();
                    end
                    else if (sel < 60)
                    begin
                        case ($urandom_range(3))
                            0: put_word("fil", 1'b1);
                            1: put_word("fiie", 1'b1);
                            2: put_word("xfile", 1'b1);
                            default: put_word("f", 1'b1);
                        endcase
                        put_byte(CH_EQ);
                        put_value();
                    end
                    else if (sel < 80)
                    begin
                        case ($urandom_range(3))
                            0: put_word("title1", 1'b1);
                            1: put_word("length1", 1'b1);
                            2: put_word("numberofentries", 1'b1);
                            default: put_word("version", 1'b1);
                        endcase
                        put_byte(CH_EQ);
                        put_value();
                    end
                    else if (sel < 85)
                    begin
                        put_byte(CH_EQ);
                        put_value();
                    end
                    else
                    begin
                        put_word("junk", 1'b1);
                    end
                end
                if ($urandom_range(3) != 0)
                    put_eol();
            end
            put_byte(CH_EOT);
        end

        // empty file entries, run with no idling on either side
        calm_lo = text_q.size();
        put_word("[playlist]", 1'b1);
        repeat (CALM_ENTRIES)
        begin
            put_eol();
            put_word("file", 1'b1);
            put_byte(CH_EQ);
        end
        put_eol();
        put_byte(CH_EOT);
        calm_hi = text_q.size();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (in_count < text_q.size())
        begin
            @(posedge clk);
        end
        while (result_due_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        if (mismatches == 0 && result_due_q.size() == 0)
        begin
            $display("pls_playlist_file_entry_parser_core regression: pass");
        end
        else
        begin
            $display("pls_playlist_file_entry_parser_core regression: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/pls_pkg.sv
hw/rtl/pls_parse_step.sv
hw/rtl/pls_result_fifo.sv
hw/rtl/pls_playlist_file_entry_parser_core.sv
dv/tb_pls_playlist_file_entry_parser_core.sv
